FILE: rtl/core/weighted_vector_field_renormalizer_core_assert.svh
// Assertion macros used by the core RTL.
`ifndef WEIGHTED_VECTOR_FIELD_RENORMALIZER_CORE_ASSERT_SVH
`define WEIGHTED_VECTOR_FIELD_RENORMALIZER_CORE_ASSERT_SVH

`ifndef SYNTH
`define WVFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WVFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WVFR_ASSERT(lbl, prop, msg)
`define WVFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/wvfr_pkg.sv
`default_nettype none
package wvfr_pkg;

  localparam int unsigned DEF_MAX_FACES = 64;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned AREA_W    = 16;
  localparam int unsigned TSD_W     = 31;
  localparam int unsigned WSUM_W    = 22;
  localparam int unsigned WS_W      = 54;
  localparam int unsigned PROD_W    = 49;
  localparam int unsigned MEAN_W    = 34;
  localparam int unsigned DIFF_W    = 35;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned RT_W      = 32;
  localparam int unsigned PR_W      = 80;
  localparam int unsigned ACC_W     = 88;
  localparam int unsigned DIVN_W    = 88;
  localparam int unsigned DIVD_W    = 34;
  localparam int unsigned P_W       = 63;
  localparam int unsigned QM_W      = 35;
  localparam int unsigned SUM_W     = 37;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LANES     = 3;

  localparam logic signed [VAL_W-1:0] TMEAN_X_RST = 32'sd4637327;
  localparam logic signed [VAL_W-1:0] TMEAN_RST   = 32'sd0;
  localparam logic [TSD_W-1:0]        TSD_RST     = 31'd46373;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_TMEAN_X = 3'd1,
    REG_TMEAN_Y = 3'd2,
    REG_TMEAN_Z = 3'd3,
    REG_TSD_X   = 3'd4,
    REG_TSD_Y   = 3'd5,
    REG_TSD_Z   = 3'd6
  } wvfr_reg_e;

  typedef struct packed {
    logic load;
    logic feed;
    logic close;
    logic sd_go;
    logic out_go;
    logic ack;
    logic bypass;
  } wvfr_ctl_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } wvfr_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/wvfr_div.sv
`default_nettype none
module wvfr_div import wvfr_pkg::*; #(
  parameter int unsigned N = DIVN_W,
  parameter int unsigned D = DIVD_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         busy_o,
  output logic [N-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic             run_q;
  logic [CNT_W-1:0] cnt_q;
  logic [D-1:0]     rem_q;
  logic [D-1:0]     dvs_q;
  logic [N-1:0]     quo_q;
  logic [D:0]       trial;
  logic [D:0]       diff;
  logic             ge;

  // restoring, one quotient bit per cycle
  assign trial = {rem_q, quo_q[N-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = ge ? (trial - {1'b0, dvs_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CNT_W'(N);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[N-2:0], ge};
      rem_q <= diff[D-1:0];
    end
  end

  assign busy_o     = run_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/wvfr_sqrt.sv
`default_nettype none
module wvfr_sqrt import wvfr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] radicand_i,
  output logic            busy_o,
  output logic [RT_W-1:0] root_o
);

  logic            run_q;
  logic [SQ_W-1:0] n_q;
  logic [SQ_W-1:0] r_q;
  logic [SQ_W-1:0] bit_q;
  logic [SQ_W-1:0] t;
  logic            ge;

  assign t  = r_q + bit_q;
  assign ge = n_q >= t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (run_q && bit_q[0]) begin
      run_q <= 1'b0;
    end
  end

  // digit-by-digit, two radicand bits per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (run_q) begin
      if (ge) begin
        n_q <= n_q - t;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = run_q;
  assign root_o = r_q[RT_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/wvfr_lane.sv
`default_nettype none
module wvfr_lane import wvfr_pkg::*; #(
  parameter int unsigned MAX_FACES = DEF_MAX_FACES,
  parameter int unsigned IDX_W     = $clog2(DEF_MAX_FACES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wvfr_ctl_t               ctl_i,
  input  logic [IDX_W-1:0]        wr_addr_i,
  input  logic [IDX_W-1:0]        rd_addr_i,
  input  logic signed [VAL_W-1:0] wr_data_i,
  input  logic [AREA_W-1:0]       area_i,
  input  logic [AREA_W-1:0]       rd_area_i,
  input  logic [WSUM_W-1:0]       w_i,
  input  logic signed [VAL_W-1:0] tmean_i,
  input  logic [TSD_W-1:0]        tsd_i,
  output wvfr_sts_t               sts_o,
  output logic signed [VAL_W-1:0] res_o,
  output logic                    clip_o
);

  typedef enum logic [3:0] {
    L_IDLE, L_MEAN, L_VDIV, L_SQRT, L_OMUL, L_OSTART, L_ODIV, L_OFIN, L_DONE
  } lane_state_e;

  lane_state_e state_q;

  logic signed [VAL_W-1:0]  mem [MAX_FACES];
  logic signed [VAL_W-1:0]  rd_q;
  logic                     ld_v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [WS_W-1:0]   ws_q;
  logic [WS_W-1:0]          ws_mag;
  logic                     neg_mean_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic [RT_W-1:0]          sd_q;

  logic signed [DIFF_W-1:0] d_c;
  logic [VAL_W-1:0]         m_c;
  logic                     va_q, vb_q, vc_q;
  logic [VAL_W-1:0]         ma_q;
  logic [AREA_W-1:0]        aa_q, ab_q;
  logic [SQ_W-1:0]          sq_q;
  logic [PR_W-1:0]          pr_q;
  logic [ACC_W-1:0]         acc_q;

  logic signed [DIFF_W-1:0] od_q;
  logic [VAL_W-1:0]         om_q;
  logic [P_W-1:0]           p_q;

  logic                     div_start, div_busy;
  logic [DIVN_W-1:0]        div_dvd, div_quo;
  logic [DIVD_W-1:0]        div_dvs;
  logic                     sq_start, sq_busy;
  logic [RT_W-1:0]          sq_root;

  logic                     q_big;
  logic [QM_W-1:0]          qm;
  logic signed [SUM_W-1:0]  q_s, sum_s;
  logic                     sat_hi, sat_lo;
  logic signed [VAL_W-1:0]  res_c;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  // weighted sum while loading
  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, area_i}) * wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_v_q <= 1'b0;
      ws_q   <= '0;
    end else begin
      ld_v_q <= ctl_i.load;
      if (ctl_i.close) begin
        ws_q <= '0;
      end else if (ld_v_q) begin
        ws_q <= ws_q + WS_W'(prod_q);
      end
    end
  end

  assign ws_mag = ws_q[WS_W-1] ? WS_W'(-ws_q) : WS_W'(ws_q);

  assign d_c = DIFF_W'(rd_q) - DIFF_W'(mean_q);
  assign m_c = d_c[DIFF_W-1] ? VAL_W'(-d_c) : VAL_W'(d_c);

  // variance pipe: diff, square, area product, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      va_q <= ctl_i.feed;
      vb_q <= va_q;
      vc_q <= vb_q;
      if (ctl_i.close) begin
        acc_q <= '0;
      end else if (vc_q) begin
        acc_q <= acc_q + ACC_W'(pr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q <= m_c;
    aa_q <= rd_area_i;
    sq_q <= ma_q * ma_q;
    ab_q <= aa_q;
    pr_q <= ab_q * sq_q;
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    if (ctl_i.close && !ctl_i.bypass) begin
      div_start = 1'b1;
      div_dvd   = DIVN_W'({ws_mag, 1'b0}) + DIVN_W'(w_i);
      div_dvs   = DIVD_W'({w_i, 1'b0});
    end else if (ctl_i.sd_go) begin
      div_start = 1'b1;
      div_dvd   = acc_q;
      div_dvs   = DIVD_W'(w_i);
    end else if (state_q == L_OSTART && sd_q != '0) begin
      div_start = 1'b1;
      div_dvd   = DIVN_W'({p_q, 1'b0}) + DIVN_W'(sd_q);
      div_dvs   = DIVD_W'({sd_q, 1'b0});
    end
  end

  wvfr_div #(.N(DIVN_W), .D(DIVD_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign sq_start = (state_q == L_VDIV) && !div_busy;

  wvfr_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (div_quo[SQ_W-1:0]),
    .busy_o     (sq_busy),
    .root_o     (sq_root)
  );

  // scaled deviation, clamp, offset and saturate
  assign q_big = (|div_quo[DIVN_W-1:QM_W]) ||
                 (div_quo[QM_W-1] && (|div_quo[QM_W-2:0]));
  assign qm    = q_big ? {1'b1, {(QM_W-1){1'b0}}} : div_quo[QM_W-1:0];

  always_comb begin
    if (sd_q == '0) begin
      q_s = SUM_W'(od_q);
    end else if (od_q[DIFF_W-1]) begin
      q_s = -$signed({2'b00, qm});
    end else begin
      q_s = $signed({2'b00, qm});
    end
    sum_s  = SUM_W'(tmean_i) + q_s;
    sat_hi = sum_s > SUM_W'(32'sh7fff_ffff);
    sat_lo = sum_s < SUM_W'(32'sh8000_0000);
    if (sat_hi) begin
      res_c = 32'sh7fff_ffff;
    end else if (sat_lo) begin
      res_c = 32'sh8000_0000;
    end else begin
      res_c = VAL_W'(sum_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= L_IDLE;
      neg_mean_q <= 1'b0;
      mean_q     <= '0;
      sd_q       <= '0;
      od_q       <= '0;
      om_q       <= '0;
      p_q        <= '0;
      res_o      <= '0;
      clip_o     <= 1'b0;
    end else begin
      case (state_q)
        L_IDLE: begin
          if (ctl_i.close && !ctl_i.bypass) begin
            neg_mean_q <= ws_q[WS_W-1];
            state_q    <= L_MEAN;
          end else if (ctl_i.sd_go) begin
            state_q <= L_VDIV;
          end else if (ctl_i.out_go) begin
            if (ctl_i.bypass) begin
              res_o  <= rd_q;
              clip_o <= 1'b0;
              state_q <= L_DONE;
            end else begin
              od_q    <= d_c;
              om_q    <= m_c;
              state_q <= L_OMUL;
            end
          end
        end
        L_MEAN: begin
          if (!div_busy) begin
            mean_q  <= neg_mean_q ? -$signed(div_quo[MEAN_W-1:0])
                                  : $signed(div_quo[MEAN_W-1:0]);
            state_q <= L_IDLE;
          end
        end
        L_VDIV: begin
          if (!div_busy) begin
            state_q <= L_SQRT;
          end
        end
        L_SQRT: begin
          if (!sq_busy) begin
            sd_q    <= sq_root;
            state_q <= L_IDLE;
          end
        end
        L_OMUL: begin
          p_q     <= om_q * tsd_i;
          state_q <= L_OSTART;
        end
        L_OSTART: begin
          state_q <= (sd_q == '0) ? L_OFIN : L_ODIV;
        end
        L_ODIV: begin
          if (!div_busy) begin
            state_q <= L_OFIN;
          end
        end
        L_OFIN: begin
          res_o   <= res_c;
          clip_o  <= sat_hi || sat_lo;
          state_q <= L_DONE;
        end
        L_DONE: begin
          if (ctl_i.ack) begin
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign sts_o.busy      = (state_q != L_IDLE && state_q != L_DONE) || va_q || vb_q || vc_q;
  assign sts_o.res_valid = state_q == L_DONE;

endmodule
`default_nettype wire

FILE: rtl/core/weighted_vector_field_renormalizer_core.sv
`default_nettype none
// Area-weighted mean/stdev renormalizer for a patch of x,y,z Q16.16 vectors. A request carries
// one face; faces are stored at one per cycle until last_face_i or until MAX_FACES are held.
// The patch then closes: three component lanes, each with its own restoring divider (shared by
// all of that lane's divides) and square root, compute the rounded mean, stream the faces
// through a variance multiply-accumulate, divide by the total area and take the root. Every
// stored face is then emitted in order as target_mean + round(target_sd/sd * (value - mean)),
// or target_mean + (value - mean) when sd is zero, saturated, with clipped_o set when any
// component saturated; faces are worked one at a time, the next only after the last is emitted.
// With enable clear or zero total area, faces return unchanged. New faces are taken once the
// last result sits in the output register. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; enable is sampled when a patch closes, the targets are read live.
module weighted_vector_field_renormalizer_core import wvfr_pkg::*; #(
  parameter int unsigned MAX_FACES = DEF_MAX_FACES
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [VAL_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [AREA_W-1:0]       face_area_i,
  input  logic signed [VAL_W-1:0] value_x_i,
  input  logic signed [VAL_W-1:0] value_y_i,
  input  logic signed [VAL_W-1:0] value_z_i,
  input  logic                    last_face_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] out_x_o,
  output logic signed [VAL_W-1:0] out_y_o,
  output logic signed [VAL_W-1:0] out_z_o,
  output logic                    clipped_o,
  output logic                    last_out_o
);

`include "weighted_vector_field_renormalizer_core_assert.svh"

  localparam int unsigned IDX_W = $clog2(MAX_FACES);
  localparam int unsigned CNT_W = $clog2(MAX_FACES + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_SETTLE, S_CLOSE, S_MEAN_W, S_VAR, S_VAR_W, S_SD, S_SD_W,
    S_OADDR, S_OGO, S_OWAIT
  } seq_state_e;

  seq_state_e state_q;

  logic                    enable_q;
  logic signed [VAL_W-1:0] tmean_q [LANES];
  logic [TSD_W-1:0]        tsd_q [LANES];

  logic [AREA_W-1:0] amem [MAX_FACES];
  logic [AREA_W-1:0] area_rd_q;

  logic [CNT_W-1:0]  cnt_q, n_q;
  logic [IDX_W-1:0]  ptr_q;
  logic [WSUM_W-1:0] area_sum_q, w_q;
  logic              bypass_q, feed_q;

  logic              accept, close_now, emit, last_c, ptr_last;
  logic              any_busy, all_valid;
  wvfr_ctl_t         ctl;
  wvfr_sts_t         sts [LANES];
  logic signed [VAL_W-1:0] wr_data [LANES];
  logic signed [VAL_W-1:0] res [LANES];
  logic [LANES-1:0]  clip, busy_v, valid_v;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                    clipped_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      tmean_q[0] <= TMEAN_X_RST;
      tmean_q[1] <= TMEAN_RST;
      tmean_q[2] <= TMEAN_RST;
      tsd_q[0]   <= TSD_RST;
      tsd_q[1]   <= TSD_RST;
      tsd_q[2]   <= TSD_RST;
    end else if (cfg_we_i) begin
      case (wvfr_reg_e'(cfg_idx_i))
        REG_ENABLE:  enable_q   <= cfg_data_i[0];
        REG_TMEAN_X: tmean_q[0] <= cfg_data_i;
        REG_TMEAN_Y: tmean_q[1] <= cfg_data_i;
        REG_TMEAN_Z: tmean_q[2] <= cfg_data_i;
        REG_TSD_X:   tsd_q[0]   <= cfg_data_i[TSD_W-1:0];
        REG_TSD_Y:   tsd_q[1]   <= cfg_data_i[TSD_W-1:0];
        REG_TSD_Z:   tsd_q[2]   <= cfg_data_i[TSD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = state_q == S_LOAD;
  assign accept     = in_valid_i && in_ready_o;
  assign close_now  = last_face_i || (cnt_q == CNT_W'(MAX_FACES - 1));
  assign ptr_last   = CNT_W'(ptr_q) == (n_q - CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      amem[cnt_q[IDX_W-1:0]] <= face_area_i;
    end
    area_rd_q <= amem[ptr_q];
  end

  assign ctl.load   = accept;
  assign ctl.feed   = feed_q;
  assign ctl.close  = state_q == S_CLOSE;
  assign ctl.sd_go  = state_q == S_SD;
  assign ctl.out_go = state_q == S_OGO;
  assign ctl.ack    = emit;
  assign ctl.bypass = bypass_q;

  assign wr_data[0] = value_x_i;
  assign wr_data[1] = value_y_i;
  assign wr_data[2] = value_z_i;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    wvfr_lane #(.MAX_FACES(MAX_FACES), .IDX_W(IDX_W)) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .wr_addr_i (cnt_q[IDX_W-1:0]),
      .rd_addr_i (ptr_q),
      .wr_data_i (wr_data[g]),
      .area_i    (face_area_i),
      .rd_area_i (area_rd_q),
      .w_i       (w_q),
      .tmean_i   (tmean_q[g]),
      .tsd_i     (tsd_q[g]),
      .sts_o     (sts[g]),
      .res_o     (res[g]),
      .clip_o    (clip[g])
    );
    assign busy_v[g]  = sts[g].busy;
    assign valid_v[g] = sts[g].res_valid;
  end

  assign any_busy  = |busy_v;
  assign all_valid = &valid_v;
  assign emit      = (state_q == S_OWAIT) && all_valid && (!out_valid_q || out_ready_i);
  assign last_c    = ptr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      n_q        <= '0;
      ptr_q      <= '0;
      area_sum_q <= '0;
      w_q        <= '0;
      bypass_q   <= 1'b0;
      feed_q     <= 1'b0;
    end else begin
      feed_q <= state_q == S_VAR;
      case (state_q)
        S_LOAD: begin
          if (accept) begin
            area_sum_q <= area_sum_q + WSUM_W'(face_area_i);
            if (close_now) begin
              n_q     <= cnt_q + CNT_W'(1);
              cnt_q   <= '0;
              state_q <= S_SETTLE;
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        S_SETTLE: begin
          w_q        <= area_sum_q;
          bypass_q   <= !(enable_q && area_sum_q != '0);
          area_sum_q <= '0;
          state_q    <= S_CLOSE;
        end
        S_CLOSE: begin
          ptr_q   <= '0;
          state_q <= bypass_q ? S_OADDR : S_MEAN_W;
        end
        S_MEAN_W: begin
          if (!any_busy) begin
            state_q <= S_VAR;
          end
        end
        S_VAR: begin
          if (ptr_last) begin
            state_q <= S_VAR_W;
          end else begin
            ptr_q <= ptr_q + IDX_W'(1);
          end
        end
        S_VAR_W: begin
          if (!feed_q && !any_busy) begin
            state_q <= S_SD;
          end
        end
        S_SD: state_q <= S_SD_W;
        S_SD_W: begin
          if (!any_busy) begin
            ptr_q   <= '0;
            state_q <= S_OADDR;
          end
        end
        S_OADDR: state_q <= S_OGO;
        S_OGO:   state_q <= S_OWAIT;
        S_OWAIT: begin
          if (emit) begin
            if (ptr_last) begin
              state_q <= S_LOAD;
            end else begin
              ptr_q   <= ptr_q + IDX_W'(1);
              state_q <= S_OADDR;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // merge lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q   <= res[0];
      out_y_q   <= res[1];
      out_z_q   <= res[2];
      clipped_q <= |clip;
      last_q    <= last_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign clipped_o   = clipped_q;
  assign last_out_o  = last_q;

  `WVFR_ASSERT(a_ready_lanes_idle, in_ready_o |-> !any_busy, "request taken while lanes busy")
  `WVFR_ASSERT(a_cnt_range, cnt_q < CNT_W'(MAX_FACES), "face count past store depth")
  `WVFR_ASSERT_NEXT(a_last_reopens, emit && last_c, in_ready_o, "patch did not reopen")
  `WVFR_ASSERT(a_emit_in_patch, emit |-> (CNT_W'(ptr_q) < n_q), "emit beyond stored faces")

endmodule
`default_nettype wire
